>>> design/shs_pkg.sv
// shared types, constants and functions for the streaming sha-256 hasher
package shs_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] PAD_MARKER = 64'h0000_0000_0000_0080;

    typedef struct packed {
        logic [63:0] data_word;
        logic        holds_word;
        logic        end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } out_item_t;

    // one 512-bit block handed from the front to the compression engine
    typedef struct packed {
        logic [7:0][63:0] words;
        logic             final_blk;
    } job_t;

    localparam logic [31:0] INITIAL_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] x);
        return {bswap32(x[31:0]), bswap32(x[63:32])};
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> design/shs_front.sv
// front end: collects words into blocks, pads on end of message, issues block jobs
module shs_front
    import shs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     push_valid,
    output job_t     push_job,
    input  logic     queue_full
);

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_PAD,
        ST_LEN
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [63:0]  buf_reg [8];
    logic [2:0]   words_reg, words_next;
    logic [63:0]  bits_reg, bits_next;
    logic         accept;
    logic [7:0][63:0] pad_words;

    assign s_ready = (state_reg == ST_TAKE) && !queue_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < words_reg) begin
                pad_words[i] = buf_reg[i];
            end else if (3'(i) == words_reg) begin
                pad_words[i] = PAD_MARKER;
            end else begin
                pad_words[i] = '0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        words_next = words_reg;
        bits_next  = bits_reg;
        push_valid = 1'b0;
        push_job   = '0;
        case (state_reg)
            ST_TAKE: begin
                if (accept) begin
                    if (s_data.holds_word) begin
                        words_next = words_reg + 3'd1;
                        bits_next  = bits_reg + 64'd64;
                        if (words_reg == 3'd7) begin
                            // block filled by this transaction
                            push_valid = 1'b1;
                            for (int i = 0; i < 7; i++) begin
                                push_job.words[i] = buf_reg[i];
                            end
                            push_job.words[7]  = s_data.data_word;
                            push_job.final_blk = 1'b0;
                        end
                    end
                    if (s_data.end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (!queue_full) begin
                    push_valid     = 1'b1;
                    push_job.words = pad_words;
                    if (words_reg == 3'd7) begin
                        // no room for the length, it goes into an extra block
                        push_job.final_blk = 1'b0;
                        state_next         = ST_LEN;
                    end else begin
                        push_job.words[7]  = bswap64(bits_reg);
                        push_job.final_blk = 1'b1;
                        words_next         = '0;
                        bits_next          = '0;
                        state_next         = ST_TAKE;
                    end
                end
            end
            ST_LEN: begin
                if (!queue_full) begin
                    push_valid         = 1'b1;
                    push_job.words[7]  = bswap64(bits_reg);
                    push_job.final_blk = 1'b1;
                    words_next         = '0;
                    bits_next          = '0;
                    state_next         = ST_TAKE;
                end
            end
            default: begin
                state_next = ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_TAKE;
            words_reg <= '0;
            bits_reg  <= '0;
        end else begin
            state_reg <= state_next;
            words_reg <= words_next;
            bits_reg  <= bits_next;
        end
        if (accept && s_data.holds_word) begin
            buf_reg[words_reg] <= s_data.data_word;
        end
    end

endmodule

>>> design/shs_queue.sv
// short fifo of block jobs between front end and compression engine
module shs_queue
    import shs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push, do_pop;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QUEUE_PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> design/shs_back.sv
// compression engine: one round per cycle, chaining hash and digest output
module shs_back
    import shs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      queue_empty,
    input  job_t      pop_job,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } back_state_t;

    back_state_t state_reg;
    logic [31:0] chain_reg  [8];
    logic [31:0] vars_reg   [8];
    logic [31:0] win_reg    [16];
    logic [31:0] digest_reg [8];
    logic [5:0]  round_reg;
    logic [1:0]  part_reg;
    logic        final_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic [31:0] t1, t2, ch, maj, w_new;
    logic [31:0] sum [8];
    logic [1:0]  part_next;

    assign pop     = (state_reg == ST_IDLE) && !queue_empty;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        ch    = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        maj   = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
              ^ (vars_reg[1] & vars_reg[2]);
        t1    = vars_reg[7] + big_sigma1(vars_reg[4]) + ch + ROUND_K[round_reg] + win_reg[0];
        t2    = big_sigma0(vars_reg[0]) + maj;
        // schedule word sixteen rounds ahead
        w_new = small_sigma1(win_reg[14]) + win_reg[9] + small_sigma0(win_reg[1]) + win_reg[0];
        for (int i = 0; i < 8; i++) begin
            sum[i] = chain_reg[i] + vars_reg[i];
        end
        part_next = part_reg + 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            round_reg   <= '0;
            part_reg    <= '0;
            final_reg   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= INITIAL_HASH[i];
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (!queue_empty) begin
                        for (int i = 0; i < 8; i++) begin
                            win_reg[2*i]   <= bswap32(pop_job.words[i][31:0]);
                            win_reg[2*i+1] <= bswap32(pop_job.words[i][63:32]);
                            vars_reg[i]    <= chain_reg[i];
                        end
                        final_reg <= pop_job.final_blk;
                        round_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    vars_reg[7] <= vars_reg[6];
                    vars_reg[6] <= vars_reg[5];
                    vars_reg[5] <= vars_reg[4];
                    vars_reg[4] <= vars_reg[3] + t1;
                    vars_reg[3] <= vars_reg[2];
                    vars_reg[2] <= vars_reg[1];
                    vars_reg[1] <= vars_reg[0];
                    vars_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) begin
                        win_reg[i] <= win_reg[i+1];
                    end
                    win_reg[15] <= w_new;
                    round_reg   <= round_reg + 6'd1;
                    if (round_reg == 6'd63) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (final_reg) begin
                        for (int i = 0; i < 8; i++) begin
                            digest_reg[i] <= sum[i];
                            chain_reg[i]  <= INITIAL_HASH[i];
                        end
                        m_valid_reg            <= 1'b1;
                        m_data_reg.digest_part <= {sum[0], sum[1]};
                        m_data_reg.part_index  <= 2'd0;
                        m_data_reg.last_part   <= 1'b0;
                        part_reg               <= 2'd0;
                        state_reg              <= ST_EMIT;
                    end else begin
                        for (int i = 0; i < 8; i++) begin
                            chain_reg[i] <= sum[i];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        if (part_reg == 2'd3) begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end else begin
                            m_data_reg.digest_part <= {digest_reg[{part_next, 1'b0}],
                                                       digest_reg[{part_next, 1'b1}]};
                            m_data_reg.part_index  <= part_next;
                            m_data_reg.last_part   <= (part_next == 2'd3);
                            part_reg               <= part_next;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/sha256_stream_hasher.sv
// Streaming SHA-256 hasher, top level.
// Input channel (s_valid/s_ready/s_data): one 64-bit message word per transaction,
// least significant byte first in message order. holds_word says whether the word
// belongs to the message; end_of_message closes it (holds_word 0 with end 1 ends
// the message without a word, which also hashes an empty message).
// Result channel (m_valid/m_ready/m_data): four transactions per message, the
// 256-bit digest in 64-bit parts, most significant first, last_part on the fourth.
// Throughput: words enter at one per cycle while no padding block is being issued,
// until the block queue (two blocks) is full. The compression engine takes one
// 512-bit block at a time: load, 64 rounds at one round per cycle, chaining add.
// Closing a message builds one padding block, or two when seven words sit in the
// partial block; the first digest part is registered in the chaining add of the last
// block, and the parts follow one per cycle while the receiver is ready.
// When the receiver stalls, the digest waits in the output register and the engine
// holds; the front end keeps taking words until the queue fills.
// Reset (aresetn low, synchronous) empties the queue, clears the bit counter and
// partial-block count and reloads the initial hash values.
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic push_valid, queue_full, queue_empty, pop;
    job_t push_job, pop_job;

    shs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    shs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .pop_job    (pop_job),
        .empty      (queue_empty)
    );

    shs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .pop_job     (pop_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

>>> design/shs_checker.sv
// port-level checks on the hasher result channel, bound to the top level
module shs_checker
    import shs_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // digest parts come back to back in order
    a_next_part: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_part |=>
            m_valid && (m_data.part_index == 2'($past(m_data.part_index) + 2'd1)))
        else $error("digest parts out of order");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_part == (m_data.part_index == 2'd3)))
        else $error("last_part does not match part_index");

    a_first_part: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_data.part_index == 2'd0))
        else $error("digest does not start at part zero");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
